// File: rtl/core/ahfr_pkg.sv
// Shared types and constants of the ASCII hex frame receiver.
package ahfr_pkg;

	localparam int QueueDepthDefault = 4;

	localparam int PosWidth = 13;
	localparam logic [PosWidth-1:0] PosMax = 13'd8191;

	localparam int InfoLenWidth = 12;
	localparam logic [13:0] FrameOverhead = 14'd17;
	localparam logic [13:0] InfoLastPos = 14'd12;

	localparam int PaddrWidth = 3;
	localparam logic RegSelCode = 1'b0;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_CHECKSUM = 3'd1,
		ST_LENGTH   = 3'd2,
		ST_CODE     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic {
		KIND_INFO   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// Work record from the front part to the back part.
	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              data;
		logic [7:0]              version;
		logic [7:0]              address;
		logic [7:0]              cmd_group;
		logic [7:0]              resp_code;
		logic [InfoLenWidth-1:0] info_len;
		logic                    first_null;
		logic [15:0]             tail_nib;
		logic [15:0]             run_sum;
		logic [PosWidth-1:0]     pos;
	} rec_t;

	// One finished result.
	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              data;
		status_t                 status;
		logic [7:0]              version;
		logic [7:0]              address;
		logic [7:0]              cmd_group;
		logic [7:0]              resp_code;
		logic [InfoLenWidth-1:0] info_len;
	} res_t;

endpackage

// File: rtl/core/ahfr_front.sv
// Front part: takes characters, tracks frame state, issues work records.
module ahfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_code,
	input  logic           frame_end,
	output logic           rec_valid,
	output ahfr_pkg::rec_t rec
);
	import ahfr_pkg::*;

	logic [PosWidth-1:0] pos_q;
	logic [15:0]         sum_q;
	logic [7:0]          tail_q [4];
	logic [15:0]         nib_q;
	logic [3:0]          hold_q;
	logic [7:0]          hdr_q [4];
	logic [15:0]         len_q;
	logic                fnull_q;

	logic [3:0]          h;
	logic                fnull_n;
	logic [15:0]         sum_n;
	logic [15:0]         nib_n;
	logic [3:0]          hold_n;
	logic [7:0]          hdr_n [4];
	logic [15:0]         len_n;
	logic                pos_odd;
	logic                st_en;
	logic [11:0]         st_k;
	logic [7:0]          st_b;
	logic                emit;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

	always_comb begin
		h       = hex_value(char_code);
		fnull_n = (pos_q == '0) ? (char_code == 8'd0) : fnull_q;
		sum_n   = (pos_q >= 13'd5) ? sum_q + {8'd0, tail_q[3]} : sum_q;
		nib_n   = {nib_q[11:0], h};
		pos_odd = pos_q[0];
		hold_n  = (pos_q != '0 && pos_odd) ? h : hold_q;

		// Odd position holds a high nibble; even position completes a byte.
		// A final char on an odd position completes a byte with a zero low nibble.
		st_en = (pos_q != '0) && (!pos_odd || frame_end);
		st_k  = pos_odd ? pos_q[12:1] : pos_q[12:1] - 12'd1;
		st_b  = pos_odd ? {h, 4'd0} : {hold_q, h};

		hdr_n = hdr_q;
		len_n = len_q;
		if (st_en) begin
			if (st_k < 12'd4) begin
				hdr_n[st_k[1:0]] = st_b;
			end else if (st_k == 12'd4) begin
				len_n[15:8] = st_b;
			end else if (st_k == 12'd5) begin
				len_n[7:0] = st_b;
			end
		end

		emit = (pos_q != '0) && !pos_odd && !frame_end && (st_k >= 12'd6) && !fnull_n &&
			({1'b0, pos_q} <= InfoLastPos + {2'd0, len_n[11:0]});

		rec_valid      = accept && (emit || frame_end);
		rec.kind       = frame_end ? KIND_STATUS : KIND_INFO;
		rec.data       = st_b;
		rec.version    = hdr_n[0];
		rec.address    = hdr_n[1];
		rec.cmd_group  = hdr_n[2];
		rec.resp_code  = hdr_n[3];
		rec.info_len   = len_n[11:0];
		rec.first_null = fnull_n;
		rec.tail_nib   = nib_n;
		rec.run_sum    = sum_n;
		rec.pos        = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			tail_q  <= '{default: '0};
			nib_q   <= '0;
			hold_q  <= '0;
			hdr_q   <= '{default: '0};
			len_q   <= '0;
			fnull_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q   <= '0;
				sum_q   <= '0;
				tail_q  <= '{default: '0};
				nib_q   <= '0;
				hold_q  <= '0;
				hdr_q   <= '{default: '0};
				len_q   <= '0;
				fnull_q <= 1'b0;
			end else begin
				pos_q     <= (pos_q < PosMax) ? pos_q + 13'd1 : pos_q;
				sum_q     <= sum_n;
				tail_q[3] <= tail_q[2];
				tail_q[2] <= tail_q[1];
				tail_q[1] <= tail_q[0];
				tail_q[0] <= char_code;
				nib_q     <= nib_n;
				hold_q    <= hold_n;
				hdr_q     <= hdr_n;
				len_q     <= len_n;
				fnull_q   <= fnull_n;
			end
		end
	end

endmodule

// File: rtl/core/ahfr_queue.sv
// Short queue of work records between the front and back parts.
module ahfr_queue #(
	parameter int Depth = ahfr_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  ahfr_pkg::rec_t wr_data,
	input  logic           rd_en,
	output ahfr_pkg::rec_t rd_data,
	output logic           full,
	output logic           empty
);
	import ahfr_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	rec_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full    = (cnt_q == CntFull);
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntFull)
		else $error("queue count above depth");
	a_wr_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !empty)
		else $error("queue empty after a write");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !rd_en) |=> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers moved apart while full");

endmodule

// File: rtl/core/ahfr_back.sv
// Back part: runs the end-of-frame checks and holds the result register.
module ahfr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     normal_code,
	input  ahfr_pkg::rec_t rec,
	input  logic           rec_empty,
	output logic           rec_take,
	input  logic           pop,
	output logic           res_valid,
	output ahfr_pkg::res_t res
);
	import ahfr_pkg::*;

	logic    out_valid_q;
	res_t    out_q;
	res_t    res_n;
	status_t status;
	logic    sum_bad;
	logic    len_bad;

	assign rec_take  = !rec_empty && (!out_valid_q || pop);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		sum_bad = (rec.tail_nib + rec.run_sum) != 16'd0;
		len_bad = ({1'b0, rec.pos} + 14'd1) < ({2'd0, rec.info_len} + FrameOverhead);
		priority if (rec.first_null) begin
			status = ST_EMPTY;
		end else if (sum_bad) begin
			status = ST_CHECKSUM;
		end else if (len_bad) begin
			status = ST_LENGTH;
		end else if (rec.resp_code != normal_code) begin
			status = ST_CODE;
		end else begin
			status = ST_OK;
		end

		res_n.kind = rec.kind;
		if (rec.kind == KIND_STATUS) begin
			res_n.data   = 8'd0;
			res_n.status = status;
		end else begin
			res_n.data   = rec.data;
			res_n.status = ST_OK;
		end
		if (rec.kind == KIND_STATUS && rec.first_null) begin
			res_n.version   = 8'd0;
			res_n.address   = 8'd0;
			res_n.cmd_group = 8'd0;
			res_n.resp_code = 8'd0;
			res_n.info_len  = '0;
		end else begin
			res_n.version   = rec.version;
			res_n.address   = rec.address;
			res_n.cmd_group = rec.cmd_group;
			res_n.resp_code = rec.resp_code;
			res_n.info_len  = rec.info_len;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			out_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)))
		else $error("result register changed while not taken");
	a_info_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_INFO) |-> (out_q.status == ST_OK))
		else $error("info beat carries a status");
	a_empty_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_EMPTY) |->
		(out_q.version == 8'd0 && out_q.resp_code == 8'd0 && out_q.info_len == '0))
		else $error("empty frame status with header fields set");

endmodule

// File: rtl/core/ascii_hex_frame_receiver_unit.sv
// Top level of the ASCII hex frame receiver.
//
// Takes one ASCII character per input beat (push/full) of a start-marked hex
// response frame, the end-of-line already stripped, with frame_end high on the
// last character. The start marker is skipped; the hex pairs after it give
// version, address, command group, response code and a 16-bit length word
// whose low 12 bits are the info length. Info bytes come out as they decode,
// one result beat each (result_kind 0); a byte completed by the final
// character is not sent. The final character yields one status beat
// (result_kind 1): checksum first, then frame length (at least info length
// plus 17), then response code against normal_response_code; a frame that
// starts with a NUL character reports empty frame with the header fields at
// zero. Invalid hex digits count as zero. The block takes one character every
// cycle while full is low; each result passes through the record queue and
// the output register. The record queue (QueueDepth entries, four by default)
// sits between the character decoder and the check/output stage, so full only
// rises when results back up on the output side. normal_response_code sits at
// byte address 0 of the APB port; write it only while no frame is in progress.
module ascii_hex_frame_receiver_unit #(
	parameter int QueueDepth = ahfr_pkg::QueueDepthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// character input
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      char_code,
	input  logic                            frame_end,
	// result output
	output logic                            empty,
	input  logic                            pop,
	output logic                            result_kind,
	output logic [7:0]                      info_byte,
	output logic [2:0]                      frame_status,
	output logic [7:0]                      version,
	output logic [7:0]                      address,
	output logic [7:0]                      command_group,
	output logic [7:0]                      response_code,
	output logic [ahfr_pkg::InfoLenWidth-1:0] info_length,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ahfr_pkg::PaddrWidth-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import ahfr_pkg::*;

	logic       accept;
	logic       rec_valid;
	rec_t       front_rec;
	rec_t       queue_rec;
	logic       queue_full;
	logic       queue_empty;
	logic       rec_take;
	logic       res_valid;
	res_t       res;
	logic [7:0] normal_code_q;

	// Accept a character whenever the record queue has room.
	assign accept = push && !full;
	assign full   = queue_full;

	ahfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.frame_end (frame_end),
		.rec_valid (rec_valid),
		.rec       (front_rec)
	);

	ahfr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (front_rec),
		.rd_en   (rec_take),
		.rd_data (queue_rec),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	ahfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.normal_code (normal_code_q),
		.rec         (queue_rec),
		.rec_empty   (queue_empty),
		.rec_take    (rec_take),
		.pop         (pop),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Drive the result ports from the output register.
	assign empty         = !res_valid;
	assign result_kind   = res.kind;
	assign info_byte     = res.data;
	assign frame_status  = res.status;
	assign version       = res.version;
	assign address       = res.address;
	assign command_group = res.cmd_group;
	assign response_code = res.resp_code;
	assign info_length   = res.info_len;

	// APB register: one word, address bit 2 selects it; low bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegSelCode) ? {24'd0, normal_code_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_code_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegSelCode) begin
			normal_code_q <= pwdata[7:0];
		end
	end

endmodule

// File: sim/tb_ascii_hex_frame_receiver_unit.sv
// Self-checking testbench for the ASCII hex frame receiver unit.
`timescale 1ns / 100ps

module tb_ascii_hex_frame_receiver_unit;
	import ahfr_pkg::*;

	// Generous cycle limit for the whole run.
	localparam int CycleLimit = 1_500_000;
	// Extra cycles after the last expected beat, to let the record queue and output register settle.
	localparam int DrainCycles = 12;
	localparam int RandomChars = 600;
	localparam int HoldOffCycles = 300;
	localparam logic [PaddrWidth-1:0] AddrNormalCode = '0;
	localparam logic [7:0] StartMark = 8'h7E;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic push = 1'b0;
	logic full;
	logic [7:0] char_code = 8'h00;
	logic frame_end = 1'b0;

	logic empty;
	logic pop = 1'b0;
	logic result_kind;
	logic [7:0] info_byte;
	logic [2:0] frame_status;
	logic [7:0] version;
	logic [7:0] address;
	logic [7:0] command_group;
	logic [7:0] response_code;
	logic [InfoLenWidth-1:0] info_length;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PaddrWidth-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ascii_hex_frame_receiver_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.frame_end     (frame_end),
		.empty         (empty),
		.pop           (pop),
		.result_kind   (result_kind),
		.info_byte     (info_byte),
		.frame_status  (frame_status),
		.version       (version),
		.address       (address),
		.command_group (command_group),
		.response_code (response_code),
		.info_length   (info_length),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Deframer state mirror: tracks the frame the way the block should.
	// ------------------------------------------------------------------
	logic [7:0]          normal_code;
	logic [PosWidth-1:0] char_pos;
	logic [15:0]         sum_acc;       // characters 1 .. pos-5
	logic [7:0]          last_chars [4];
	logic [15:0]         last_nibbles;  // hex values of the last four characters
	logic [3:0]          high_nibble;
	logic [7:0]          header [4];    // version, address, cid1, cid2
	logic [15:0]         len_word;
	logic                lead_null;
	res_t                expected_beats [$];

	// Test controls and run statistics.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int chars_sent = 0;
	int frames_sent = 0;
	int info_beats = 0;
	int status_beats [5] = '{0, 0, 0, 0, 0};
	int full_cycles = 0;
	int mismatches = 0;
	logic [7:0] frame_chars [$];

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
		return 4'h0;
	endfunction

	function void clear_frame_state();
		char_pos = '0;
		sum_acc = '0;
		last_chars = '{8'h00, 8'h00, 8'h00, 8'h00};
		last_nibbles = '0;
		high_nibble = '0;
		header = '{8'h00, 8'h00, 8'h00, 8'h00};
		len_word = '0;
		lead_null = 1'b0;
	endfunction

	function void put_byte(input int k, input logic [7:0] b);
		if (k < 4) header[k] = b;
		else if (k == 4) len_word[15:8] = b;
		else if (k == 5) len_word[7:0] = b;
	endfunction

	function void queue_beat(input kind_t kind, input logic [7:0] data, input status_t st,
		input bit zero_hdr);
		res_t r;
		r.kind = kind;
		r.data = data;
		r.status = st;
		r.version = zero_hdr ? 8'h00 : header[0];
		r.address = zero_hdr ? 8'h00 : header[1];
		r.cmd_group = zero_hdr ? 8'h00 : header[2];
		r.resp_code = zero_hdr ? 8'h00 : header[3];
		r.info_len = zero_hdr ? '0 : len_word[InfoLenWidth-1:0];
		expected_beats = {expected_beats, r};
	endfunction

	// Advance the mirror by one accepted character and queue any beat it causes.
	function void deframe_char(input logic [7:0] c, input logic fend);
		int p;
		int k;
		logic [3:0] h;
		logic [7:0] b;
		status_t st;
		p = char_pos;
		h = nibble_of(c);
		if (p == 0) lead_null = (c == 8'h00);
		if (p >= 5) sum_acc = sum_acc + last_chars[3];
		last_chars[3] = last_chars[2];
		last_chars[2] = last_chars[1];
		last_chars[1] = last_chars[0];
		last_chars[0] = c;
		last_nibbles = {last_nibbles[11:0], h};
		if (p >= 1) begin
			if (p % 2 == 1) begin
				high_nibble = h;
			end else begin
				k = (p - 2) / 2;
				b = {high_nibble, h};
				put_byte(k, b);
				// Emit only info bytes that lie wholly inside the info length.
				if (!fend && k >= 6 && !lead_null && p <= 12 + int'(len_word[11:0]))
					queue_beat(KIND_INFO, b, ST_OK, 1'b0);
			end
		end
		if (fend) begin
			// A dangling high nibble gets a zero low nibble.
			if (p >= 1 && p % 2 == 1) put_byte((p - 1) / 2, {high_nibble, 4'h0});
			if (lead_null) begin
				queue_beat(KIND_STATUS, 8'h00, ST_EMPTY, 1'b1);
			end else begin
				if (16'(last_nibbles + sum_acc) != 16'h0000) st = ST_CHECKSUM;
				else if (p + 1 < int'(len_word[11:0]) + 17) st = ST_LENGTH;
				else if (header[3] != normal_code) st = ST_CODE;
				else st = ST_OK;
				queue_beat(KIND_STATUS, 8'h00, st, 1'b0);
			end
			clear_frame_state();
		end else if (char_pos != PosMax) begin
			char_pos = char_pos + 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Frame construction
	// ------------------------------------------------------------------
	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
		if (n < 4'd10) return 8'h30 + n;
		return (lower ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	function void add_char(input logic [7:0] c);
		frame_chars = {frame_chars, c};
	endfunction

	function void add_hex(input logic [15:0] v, input int digits, input bit lower);
		for (int i = digits - 1; i >= 0; i--)
			add_char(hex_digit(v[4*i +: 4], lower));
	endfunction

	// Start marker, header, length word and info characters; checksum comes later.
	function void open_frame(input logic [7:0] ver, adr, grp, code, input logic [15:0] lword,
		input int n_info, input bit lower);
		frame_chars.delete();
		add_char(StartMark);
		add_hex(ver, 2, lower);
		add_hex(adr, 2, lower);
		add_hex(grp, 2, lower);
		add_hex(code, 2, lower);
		add_hex(lword, 4, lower);
		repeat (n_info) add_char(hex_digit(4'($urandom_range(15)), lower));
	endfunction

	// Append the four checksum digits; a nonzero twist breaks the checksum.
	function void close_frame(input logic [15:0] twist, input bit lower);
		logic [15:0] total;
		total = '0;
		foreach (frame_chars[i])
			if (i > 0) total = total + frame_chars[i];
		add_hex(16'(-total) ^ twist, 4, lower);
	endfunction

	// ------------------------------------------------------------------
	// Sender, receiver/checker, configuration
	// ------------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic fend);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		frame_end <= fend;
		@(posedge clk);
		while (full) @(posedge clk);
		deframe_char(c, fend);
		chars_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_chars[i]) send_char(frame_chars[i], i == frame_chars.size() - 1);
		frames_sent++;
	endtask

	// Pause the sender until every expected beat has come, then let the pipe settle.
	task automatic drain();
		push <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_normal_code(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrNormalCode;
		pwdata <= {24'h000000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		normal_code = v;
	endtask

	function void report_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected kind %0d byte %h status %0d hdr %h %h %h %h len %0d",
				$time, what, want.kind, want.data, want.status, want.version, want.address,
				want.cmd_group, want.resp_code, want.info_len,
				"\n        actual   kind %0d byte %h status %0d hdr %h %h %h %h len %0d",
				got.kind, got.data, got.status, got.version, got.address, got.cmd_group,
				got.resp_code, got.info_len);
	endfunction

	function void check_beat();
		res_t got;
		res_t want;
		got.kind = kind_t'(result_kind);
		got.data = info_byte;
		got.status = status_t'(frame_status);
		got.version = version;
		got.address = address;
		got.cmd_group = command_group;
		got.resp_code = response_code;
		got.info_len = info_length;
		if (expected_beats.size() == 0) begin
			report_mismatch("result beat with nothing expected", '0, got);
			return;
		end
		want = expected_beats.pop_front();
		if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status ||
			got.version !== want.version || got.address !== want.address ||
			got.cmd_group !== want.cmd_group || got.resp_code !== want.resp_code ||
			got.info_len !== want.info_len)
			report_mismatch("result beat mismatch", want, got);
		if (want.kind == KIND_INFO) info_beats++;
		else status_beats[want.status]++;
	endfunction

	// Take result beats; stall at random, or hold off completely while hold_off runs down.
	always @(posedge clk) begin
		if (pop && !empty) check_beat();
		if (push && full) full_cycles++;
		if (hold_off > 0) begin
			hold_off--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		repeat (CycleLimit) @(posedge clk);
		$display("Timeout: %0d beats still expected after %0d cycles",
			expected_beats.size(), CycleLimit);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic start_phase(input logic [7:0] code, input int send_pct, input int recv_pct);
		drain();
		write_normal_code(code);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Short frames, the empty frame, invalid digits and a good frame with extreme header.
	task automatic test_directed();
		start_phase(8'h00, 0, 0);
		// Lone NUL: empty frame on its first character.
		frame_chars = '{8'h00};
		send_frame();
		// Marker plus 0xFF: dangling nibble, too short.
		frame_chars = '{StartMark, 8'hFF};
		send_frame();
		// Invalid digit decodes as zero; the last character completes the version byte.
		frame_chars = '{StartMark, "G", "a"};
		send_frame();
		// NUL first with content behind it still reports an empty frame.
		frame_chars = '{8'h00, "4", "1", "X"};
		send_frame();
		// Well-formed lowercase frame with two info characters.
		open_frame(8'hFF, 8'h00, 8'hAB, normal_code, 16'hF002, 2, 1'b1);
		close_frame(16'h0000, 1'b1);
		send_frame();
	endtask

	task automatic random_frame();
		int pick;
		int ilen;
		int n_info;
		bit lower;
		logic [7:0] code;
		logic [15:0] lword;
		pick = $urandom_range(99);
		lower = $urandom_range(1);
		code = normal_code;
		ilen = $urandom_range(48);
		// Sometimes send more info characters than announced.
		n_info = ilen + (($urandom_range(3) == 0) ? $urandom_range(6) : 0);
		if (pick >= 63 && pick < 71) begin
			ilen = ($urandom_range(3) == 0) ? $urandom_range(4095, 41) : $urandom_range(40, 1);
			n_info = (ilen > 40) ? $urandom_range(40) : $urandom_range(ilen - 1);
		end else if (pick >= 71 && pick < 79) begin
			code = normal_code ^ 8'($urandom_range(255, 1));
		end
		lword = {4'($urandom_range(15)), 12'(ilen)};
		if (pick >= 91) begin
			// Noise: random bytes of random length.
			frame_chars.delete();
			repeat ($urandom_range(20, 1)) add_char(8'($urandom_range(255)));
		end else begin
			open_frame(8'($urandom), 8'($urandom), 8'($urandom), code, lword, n_info, lower);
			if (pick >= 79 && pick < 86) begin
				// Drop random bytes into the frame body.
				repeat ($urandom_range(3, 1))
					frame_chars[$urandom_range(frame_chars.size() - 1, 1)] =
						8'($urandom_range(255));
			end else if (pick >= 86) begin
				frame_chars[0] = 8'h00;
			end
			close_frame((pick >= 55 && pick < 63) ? 16'($urandom_range(65535, 1)) : 16'h0000,
				lower);
		end
		send_frame();
	endtask

	task automatic test_random_phase(input logic [7:0] code, input int send_pct,
		input int recv_pct);
		int stop_at;
		start_phase(code, send_pct, recv_pct);
		stop_at = chars_sent + RandomChars / 4;
		while (chars_sent < stop_at) random_frame();
	endtask

	// Hold the receiver off while good frames keep coming, so the queue fills and full rises.
	task automatic test_backpressure();
		start_phase(8'h5A, 0, 0);
		hold_off = HoldOffCycles;
		repeat (5) begin
			open_frame(8'($urandom), 8'($urandom), 8'($urandom), normal_code, 16'h2028, 40,
				1'b0);
			close_frame(16'h0000, 1'b0);
			send_frame();
		end
	endtask

	// Sender pauses between frames until every beat has come.
	task automatic test_pause();
		start_phase(normal_code, 30, 30);
		repeat (3) begin
			random_frame();
			drain();
		end
	endtask

	// Long good frame: a hundred info beats under one running checksum.
	task automatic test_long_frame();
		start_phase(8'h46, 0, 0);
		open_frame(8'h20, 8'h02, 8'h4A, normal_code, 16'h00C8, 200, 1'b0);
		close_frame(16'h0000, 1'b0);
		send_frame();
	endtask

	initial begin
		clear_frame_state();
		normal_code = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(8'hFF, 0, 0);
		test_random_phase(8'($urandom), 58, 0);
		test_random_phase(8'h46, 0, 58);
		test_random_phase(8'($urandom), 14, 14);
		test_backpressure();
		test_pause();
		test_long_frame();
		drain();

		$display("Sent %0d frames (%0d characters) over five idling settings and a long frame",
			frames_sent, chars_sent);
		$display("Info beats %0d; status ok %0d chk %0d len %0d code %0d empty %0d; full %0d cyc",
			info_beats, status_beats[ST_OK], status_beats[ST_CHECKSUM], status_beats[ST_LENGTH],
			status_beats[ST_CODE], status_beats[ST_EMPTY], full_cycles);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatching result beats", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
